@@ design/pvd_pkg.sv @@
`default_nettype none

package pvd_pkg;

    localparam int WordBits  = 64;
    localparam int ByteBits  = 8;
    localparam int ExtraBits = 3;

    // configuration register indexes
    localparam logic CfgSignedMode = 1'b0;
    localparam logic CfgWideMode   = 1'b1;

    // one complete integer handed from the byte gatherer to the result stage
    typedef struct packed {
        logic                   valid;
        logic [WordBits-1:0]    raw;
        logic [ExtraBits-1:0]   extra;
    } t_fin;

    // trailing zero count of the lead byte; a zero byte counts as 0
    function automatic logic [ExtraBits-1:0] low_zeros(input logic [ByteBits-1:0] b);
        logic [ExtraBits-1:0] n;
        n = '0;
        for (int k = ByteBits - 1; k >= 0; k--) begin
            if (b[k]) begin
                n = ExtraBits'(k);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ design/pvd_gather.sv @@
`default_nettype none

module pvd_gather
    import pvd_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [ByteBits-1:0] i_byte,
    output t_fin                     o_fin
);

    localparam int GathBits = MAX_BYTES * ByteBits;

    logic [GathBits-1:0]  r_gath, n_gath;
    logic [ExtraBits-1:0] r_rem, n_rem;
    logic [ExtraBits-1:0] r_extra, n_extra;
    logic [ExtraBits-1:0] r_taken, n_taken;

    logic [GathBits-1:0]  merged;
    logic [ExtraBits-1:0] lead_extra;

    always_comb begin
        merged = r_gath;
        // slot 0 holds the lead byte; slots past the buffer are dropped
        for (int k = 1; k < MAX_BYTES; k++) begin
            if (r_taken == ExtraBits'(k - 1)) begin
                merged[k*ByteBits +: ByteBits] = i_byte;
            end
        end
    end

    assign lead_extra = low_zeros(i_byte);

    always_comb begin
        n_gath    = r_gath;
        n_rem     = r_rem;
        n_extra   = r_extra;
        n_taken   = r_taken;
        o_fin     = '0;
        if (i_accept) begin
            if (r_rem == '0) begin
                n_gath               = '0;
                n_gath[ByteBits-1:0] = i_byte;
                n_extra              = lead_extra;
                n_taken              = '0;
                n_rem                = lead_extra;
                // a single byte item, zero markers included, ends at once
                if (lead_extra == '0) begin
                    o_fin.valid = 1'b1;
                    o_fin.raw   = WordBits'(i_byte);
                    o_fin.extra = '0;
                end
            end else begin
                n_gath  = merged;
                n_taken = r_taken + ExtraBits'(1);
                n_rem   = r_rem - ExtraBits'(1);
                if (r_rem == ExtraBits'(1)) begin
                    o_fin.valid = 1'b1;
                    o_fin.raw   = WordBits'(merged);
                    o_fin.extra = r_extra;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_extra <= '0;
            r_taken <= '0;
        end else begin
            r_rem   <= n_rem;
            r_extra <= n_extra;
            r_taken <= n_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gath <= n_gath;
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= r_extra)
        else $error("remaining byte count above extra count");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem != '0 |-> (r_taken + r_rem) == r_extra)
        else $error("taken plus remaining does not match extra count");

    a_fin_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fin.valid |=> r_rem == '0)
        else $error("integer finished but bytes still expected");

endmodule

`default_nettype wire

@@ design/pvd_emit.sv @@
`default_nettype none

module pvd_emit
    import pvd_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  t_fin                     i_fin,
    input  wire logic                i_signed_mode,
    input  wire logic                i_wide_mode,
    output logic                     o_valid,
    output logic [WordBits-1:0]      o_value_bits,
    output logic                     o_malformed
);

    localparam logic [ExtraBits:0] MaxBytes = (ExtraBits + 1)'(MAX_BYTES);

    logic                   r_valid;
    logic [WordBits-1:0]    r_value;
    logic                   r_malformed;

    logic                   bad;
    logic [WordBits-1:0]    raw;
    logic [WordBits-1:0]    shifted;
    logic [WordBits-1:0]    ext_mask;
    logic                   sign_bit;
    logic [WordBits-1:0]    n_value;
    logic [ExtraBits:0]     len;

    always_comb begin
        len      = {1'b0, i_fin.extra} + (ExtraBits + 1)'(1);
        bad      = (len > MaxBytes) || (!i_wide_mode && i_fin.extra > ExtraBits'(3));
        raw      = i_fin.raw;
        if (!i_wide_mode) begin
            raw[WordBits-1:32] = '0;
        end
        shifted  = raw >> len;
        sign_bit = 1'b0;
        ext_mask = '0;
        // payload is 7 bits per byte; sign sits at its top bit
        for (int k = 0; k < (1 << ExtraBits); k++) begin
            if (i_fin.extra == ExtraBits'(k)) begin
                sign_bit = shifted[7*k+6];
                ext_mask = ~(WordBits'(0)) << (7*(k+1));
            end
        end
        n_value = shifted;
        if (i_signed_mode && sign_bit) begin
            n_value = n_value | ext_mask;
        end
        if (!i_wide_mode) begin
            n_value[WordBits-1:32] = '0;
        end
        if (bad) begin
            n_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_fin.valid) begin
            r_value     <= n_value;
            r_malformed <= bad;
        end
    end

    assign o_valid      = r_valid;
    assign o_value_bits = r_value;
    assign o_malformed  = r_malformed;

endmodule

`default_nettype wire

@@ design/prefix_varint_decoder_core.sv @@
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_in_byte
// result    o_out_valid   i_out_stall   o_value_bits, o_malformed
// config    i_cfg_we      -             i_cfg_index, i_cfg_data
//
// One input byte is taken per cycle unless the input is stalled; an integer
// of n bytes gives its result in the cycle after its last byte is taken,
// registered in the result stage. The byte gatherer and the result register
// run in one pass, so throughput is one byte per clock while unstalled.
// Synchronous active-low reset clears the counters, the result valid and the
// modes (signed off, 64-bit words on).
// A held result that is stalled blocks new bytes; otherwise bytes keep
// flowing while the result register drains.
`default_nettype none

module prefix_varint_decoder_core
    import pvd_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ByteBits-1:0] i_in_byte,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [WordBits-1:0]      o_value_bits,
    output logic                     o_malformed,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic                i_cfg_data
);

    logic r_signed_mode;
    logic r_wide_mode;
    logic load;
    logic in_accept;
    t_fin fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
            r_wide_mode   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgSignedMode: r_signed_mode <= i_cfg_data;
                CfgWideMode:   r_wide_mode   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign load       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !load;
    assign in_accept  = i_in_valid && load;

    pvd_gather #(
        .MAX_BYTES (MAX_BYTES)
    ) u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .o_fin    (fin)
    );

    pvd_emit #(
        .MAX_BYTES (MAX_BYTES)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_fin         (fin),
        .i_signed_mode (r_signed_mode),
        .i_wide_mode   (r_wide_mode),
        .o_valid       (o_out_valid),
        .o_value_bits  (o_value_bits),
        .o_malformed   (o_malformed)
    );

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_malformed |-> o_value_bits == '0)
        else $error("malformed result carries a nonzero value");

    a_narrow_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_wide_mode |-> o_value_bits[WordBits-1:32] == '0)
        else $error("32-bit result has upper bits set");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

@@ sim/pvd_decode_checker.sv @@
`timescale 1ns / 100ps

module pvd_decode_checker
    import pvd_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [ByteBits-1:0] i_in_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [WordBits-1:0] i_value_bits,
    input  logic                i_malformed,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic                i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);

    typedef struct {
        logic [WordBits-1:0] value;
        logic                malformed;
    } t_decoded;

    t_decoded decoded_q[$];

    // shadow of the decoder state and modes
    logic [WordBits-1:0]  gathered  = '0;
    logic [ExtraBits-1:0] remaining = '0;
    logic [ExtraBits-1:0] extra     = '0;
    logic [ExtraBits-1:0] taken     = '0;
    logic                 signed_on = 1'b0;
    logic                 wide_on   = 1'b1;

    int fails   = 0;
    int checked = 0;

    assign o_fail_count   = fails;
    assign o_pending      = decoded_q.size();
    assign o_result_count = checked;

    function automatic t_decoded finish_word(input logic [WordBits-1:0] raw,
                                             input logic [ExtraBits-1:0] e,
                                             input logic sgn, input logic wide);
        t_decoded d;
        int       top;
        logic [WordBits-1:0] v;
        d.value     = '0;
        d.malformed = (int'(e) + 1 > MAX_BYTES) || (!wide && int'(e) > 3);
        if (!d.malformed) begin
            top = 7 * (int'(e) + 1);
            v = wide ? raw : {32'h0, raw[31:0]};
            v = v >> (int'(e) + 1);
            if (sgn && v[top-1]) begin
                v = v | ({WordBits{1'b1}} << top);
            end
            if (!wide) begin
                v[63:32] = '0;
            end
            d.value = v;
        end
        return d;
    endfunction

    task automatic absorb_byte(input logic [ByteBits-1:0] b);
        t_decoded zero_val;
        int       n;
        int       slot;
        zero_val.value     = '0;
        zero_val.malformed = 1'b0;
        if (remaining == 0) begin
            if (b <= 8'd1) begin
                decoded_q.push_back(zero_val);
            end else begin
                gathered = {{(WordBits-ByteBits){1'b0}}, b};
                n = 0;
                while (n < 7 && !b[n]) n++;
                extra = n[ExtraBits-1:0];
                taken = '0;
                if (extra == 0) begin
                    decoded_q.push_back(finish_word(gathered, extra, signed_on, wide_on));
                end else begin
                    remaining = extra;
                end
            end
        end else begin
            slot = int'(taken) + 1;
            if (slot < MAX_BYTES && slot < 8) begin
                gathered[8*slot +: 8] = b;
            end
            taken     = taken + ExtraBits'(1);
            remaining = remaining - ExtraBits'(1);
            if (remaining == 0) begin
                decoded_q.push_back(finish_word(gathered, extra, signed_on, wide_on));
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_decoded want;
        if (!i_rst_n) begin
            gathered  = '0;
            remaining = '0;
            extra     = '0;
            taken     = '0;
            signed_on = 1'b0;
            wide_on   = 1'b1;
            decoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected result value=%h malformed=%b",
                                 $realtime, i_value_bits, i_malformed);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    checked++;
                    if (want.value !== i_value_bits || want.malformed !== i_malformed) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch value exp=%h got=%h malformed exp=%b got=%b",
                                     $realtime, want.value, i_value_bits,
                                     want.malformed, i_malformed);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CfgSignedMode) begin
                    signed_on = i_cfg_data;
                end else begin
                    wide_on = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_byte(i_in_byte);
            end
        end
    end

endmodule

@@ sim/tb_prefix_varint_decoder_core.sv @@
`timescale 1ns / 100ps

module tb_prefix_varint_decoder_core;
    import pvd_pkg::*;

    localparam int MaxBytes    = 8;
    localparam int TotalBytes  = 1950;
    localparam int NumPhases   = 8;
    localparam int QuietLimit  = 2000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [ByteBits-1:0] i_in_byte   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_index = CfgSignedMode;
    logic                i_cfg_data  = 1'b0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [WordBits-1:0] o_value_bits;
    logic                o_malformed;

    int  fail_count;
    int  pending;
    int  result_count;
    int  bytes_sent = 0;
    int  phases_run = 0;
    bit  idle_on    = 1'b1;
    int  stall_left = 0;
    int  quiet      = 0;

    prefix_varint_decoder_core #(
        .MAX_BYTES(MaxBytes)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value_bits(o_value_bits),
        .o_malformed (o_malformed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pvd_decode_checker #(
        .MAX_BYTES(MaxBytes)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_value_bits  (o_value_bits),
        .i_malformed   (o_malformed),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    always #4 i_clk = ~i_clk;

    // receiver stalls in random bursts, only while idle_on is set
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QuietLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_byte(input logic [ByteBits-1:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // well-formed integer with e extra bytes and random payload bits
    task automatic send_int(input int e);
        int mask;
        int lead;
        mask = (1 << (e + 1)) - 1;
        lead = ($urandom_range(0, 255) & ~mask & 8'hFF) | (1 << e);
        push_byte(lead[7:0]);
        repeat (e) push_byte(ByteBits'($urandom_range(0, 255)));
    endtask

    // arbitrary lead byte, followed by whatever it asks for
    task automatic send_noise();
        logic [ByteBits-1:0] lead;
        int                  n;
        lead = ByteBits'($urandom_range(0, 255));
        push_byte(lead);
        if (lead > 8'd1) begin
            n = 0;
            while (n < 7 && !lead[n]) n++;
            repeat (n) push_byte(ByteBits'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_modes(input logic sgn, input logic wide);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CfgSignedMode;
        i_cfg_data  <= sgn;
        @(posedge i_clk);
        i_cfg_index <= CfgWideMode;
        i_cfg_data  <= wide;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic sgn, input logic wide, input int quota,
                                input bit idle);
        int start;
        int pick;
        drain();
        set_modes(sgn, wide);
        idle_on = idle;
        start   = bytes_sent;
        while (bytes_sent - start < quota) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                push_byte(ByteBits'($urandom_range(0, 1)));
            end else if (pick == 1) begin
                send_noise();
            end else if (pick < 6) begin
                send_int($urandom_range(0, 3));
            end else begin
                send_int($urandom_range(4, 7));
            end
        end
        phases_run++;
    endtask

    initial begin
        logic [1:0] modes [NumPhases];
        modes = '{2'b01, 2'b11, 2'b00, 2'b10, 2'b11, 2'b00, 2'b01, 2'b10};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modes: unsigned, 64-bit
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h02);
        push_byte(8'hFF);
        push_byte(8'h80);
        repeat (7) push_byte(8'hFF);

        // signed 32-bit: sign extension and an over-long integer
        drain();
        set_modes(1'b1, 1'b0);
        push_byte(8'hFF);
        push_byte(8'h08);
        repeat (3) push_byte(8'hFF);
        push_byte(8'h10);
        repeat (4) push_byte(8'h00);

        for (int p = 0; p < NumPhases; p++) begin
            random_phase(modes[p][1], modes[p][0], TotalBytes / NumPhases,
                         p < NumPhases - 1);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes over %0d random mode phases plus directed cases",
                 bytes_sent, phases_run);
        $display("checked %0d decoded values, %0d mismatches", result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/pvd_pkg.sv
design/pvd_gather.sv
design/pvd_emit.sv
design/prefix_varint_decoder_core.sv
sim/pvd_decode_checker.sv
sim/tb_prefix_varint_decoder_core.sv
